// ----- src/fjrs_pkg.sv -----
// ----------------------------------------------------------------------------
// fjrs_pkg
// Shared types and constants for the feeder jam recovery sequencer.
// ----------------------------------------------------------------------------
package fjrs_pkg;

  localparam int unsigned EncoderCountsDefault = 8192;
  localparam int unsigned StallMax             = 32767;
  localparam int unsigned CfgIdxW              = 3;
  localparam int unsigned CfgDataW             = 19;

  localparam logic [CfgIdxW-1:0] RegStallSpeed  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStallTicks  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFeedReverse = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShotAngle   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMagazine    = 3'd4;

  localparam logic [1:0] ModeDisabled  = 2'd0;
  localparam logic [1:0] ModeCeaseFire = 2'd1;
  localparam logic [1:0] ModeFiring    = 2'd2;
  // The spare mode code behaves as firing.
  localparam logic [1:0] ModeReserved  = 2'd3;

  typedef struct packed {
    logic [1:0]         attack_mode;
    logic [12:0]        raw_angle;
    logic signed [15:0] motor_speed;
    logic [7:0]         new_shots;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] aim_angle;
    logic signed [31:0] total_angle;
    logic               drive_enable;
    logic               jam_active;
    logic               shot_done;
    logic [15:0]        fired_count;
    logic [15:0]        remaining_count;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // latch input and run stage one
    logic div;    // one divider step
    logic fin;    // commit the tick
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } sts_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPre  = 5'b00010,
    StDiv  = 5'b00100,
    StFin  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

endpackage

// ----- src/fjrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// fjrs_ctrl
// Sequencer for one tick: load, optional divide, commit, present result.
// ----------------------------------------------------------------------------
module fjrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fjrs_pkg::sts_t sts_i,
  output fjrs_pkg::cmd_t cmd_o
);

  fjrs_pkg::state_e state_q, state_d;

  // Output is held in a register, so a new beat can be taken as it waits.
  logic out_valid_q, out_valid_d;
  logic take;

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == fjrs_pkg::StIdle);

  // Next state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      fjrs_pkg::StIdle: begin
        if (take) begin
          cmd_o.load = 1'b1;
          state_d    = fjrs_pkg::StPre;
        end
      end
      fjrs_pkg::StPre: begin
        state_d = sts_i.need_div ? fjrs_pkg::StDiv : fjrs_pkg::StFin;
      end
      fjrs_pkg::StDiv: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) state_d = fjrs_pkg::StFin;
      end
      fjrs_pkg::StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = fjrs_pkg::StIdle;
        end
      end
      fjrs_pkg::StOut: state_d = fjrs_pkg::StIdle;
      default:         state_d = fjrs_pkg::StIdle;
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.fin) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fjrs_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/fjrs_dp.sv -----
// ----------------------------------------------------------------------------
// fjrs_dp
// Angle tracking, feed, shot counting and jam recovery datapath.
// ----------------------------------------------------------------------------
module fjrs_dp #(
  parameter int unsigned EncoderCounts = fjrs_pkg::EncoderCountsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fjrs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fjrs_pkg::CfgDataW-1:0]     cfg_data_i,
  input  fjrs_pkg::in_item_t                in_data_i,
  input  fjrs_pkg::cmd_t                    cmd_i,
  output fjrs_pkg::sts_t                    sts_o,
  output fjrs_pkg::out_item_t               out_data_o
);

  localparam int unsigned EncW       = $clog2(EncoderCounts);
  localparam int unsigned WrapThresh = (EncoderCounts * 6000) / 8192;
  localparam logic signed [17:0] WrapS = 18'(WrapThresh);

  // Configuration registers.
  logic [14:0] stall_speed_q;
  logic [9:0]  stall_ticks_q;
  logic        feed_reverse_q;
  logic [18:0] shot_angle_q;
  logic [15:0] magazine_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_speed_q  <= 15'd1300;
      stall_ticks_q  <= 10'd35;
      feed_reverse_q <= 1'b0;
      shot_angle_q   <= 19'd36864;
      magazine_q     <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fjrs_pkg::RegStallSpeed:  stall_speed_q  <= cfg_data_i[14:0];
        fjrs_pkg::RegStallTicks:  stall_ticks_q  <= cfg_data_i[9:0];
        fjrs_pkg::RegFeedReverse: feed_reverse_q <= cfg_data_i[0];
        fjrs_pkg::RegShotAngle:   shot_angle_q   <= cfg_data_i;
        fjrs_pkg::RegMagazine:    magazine_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Tick state.
  logic [12:0]        last_raw_q;
  logic [31:0]        turn_q;
  logic [7:0]         pend_q;
  logic               started_q;
  logic [31:0]        feed_tgt_q;
  logic [15:0]        fired_q;
  logic [15:0]        remain_q;
  logic               jam_q;
  logic signed [16:0] stall_q;
  logic               rock_q;
  logic [31:0]        rec_q;

  // Latched beat and stage-one results.
  fjrs_pkg::in_item_t in_q;
  logic [7:0]         pend1_q;
  logic [31:0]        turn1_q;
  logic               recov_q;
  logic [31:0]        delta_q;
  logic [31:0]        dshot_q;
  logic               stalled_q;
  logic signed [16:0] stall1_q;

  // Divider: quotient parity of stall1 / divisor, restoring, 15 bits.
  logic [14:0] dq_q;
  logic [10:0] drem_q;
  logic [3:0]  dcnt_q;

  logic [31:0] delta_c;
  logic [16:0] spd_abs;
  logic signed [13:0] rdiff;
  logic [31:0] turn_c;
  logic [7:0]  pend_c;
  logic signed [16:0] st_inc;

  assign delta_c = feed_reverse_q ? (32'd0 - {13'd0, shot_angle_q}) : {13'd0, shot_angle_q};
  assign spd_abs = in_data_i.motor_speed[15] ? (17'd0 - {1'b1, in_data_i.motor_speed})
                                             : {1'b0, in_data_i.motor_speed};
  assign rdiff   = $signed({1'b0, in_data_i.raw_angle}) - $signed({1'b0, last_raw_q});
  always_comb begin
    turn_c = turn_q;
    if (rdiff < -$signed({1'b0, WrapS})) turn_c = turn_c + 32'd1;
    if (rdiff >  $signed({1'b0, WrapS})) turn_c = turn_c - 32'd1;
  end
  assign pend_c = (in_data_i.new_shots != 8'd0) ? in_data_i.new_shots : pend_q;
  assign st_inc = (stall_q < 17'sd32767) ? stall_q + 17'sd1 : stall_q;

  logic fire_mode, recov_c, stalled_c;
  assign fire_mode = (in_data_i.attack_mode != fjrs_pkg::ModeDisabled) &&
                     (in_data_i.attack_mode != fjrs_pkg::ModeCeaseFire);
  assign recov_c   = fire_mode && jam_q && (stall_q > $signed({7'd0, stall_ticks_q}));
  assign stalled_c = spd_abs < {2'd0, stall_speed_q};

  // Divider trial subtraction.
  logic [9:0]  dvsr;
  logic [10:0] dtrial;
  logic        dsub_ok;
  assign dvsr    = (stall_ticks_q == 10'd0) ? 10'd1 : stall_ticks_q;
  assign dtrial  = {drem_q[9:0], dq_q[14]};
  assign dsub_ok = dtrial >= {1'b0, dvsr};

  // Stage one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q      <= in_data_i;
      pend1_q   <= pend_c;
      turn1_q   <= turn_c;
      recov_q   <= recov_c;
      delta_q   <= delta_c;
      dshot_q   <= delta_c * {24'd0, pend_c};
      stalled_q <= stalled_c;
      stall1_q  <= (recov_c && stalled_c) ? st_inc : stall_q;
      dq_q      <= st_inc[14:0];
      drem_q    <= '0;
      dcnt_q    <= '0;
    end else if (cmd_i.div) begin
      dq_q   <= {dq_q[13:0], dsub_ok};
      drem_q <= dsub_ok ? dtrial - {1'b0, dvsr} : dtrial;
      dcnt_q <= dcnt_q + 4'd1;
    end
  end

  assign sts_o.need_div = recov_q && stalled_q;
  assign sts_o.div_last = dcnt_q == 4'd14;

  // Commit logic.
  logic [31:0] tot_c, tot_r, rec_n, ftgt_n, turn_n, ftgt_c, dist_r, dist_f, tgt_n;
  logic [12:0] lraw_n;
  logic [7:0]  pend_n;
  logic [15:0] fired_n, rem_n;
  logic        start_n, jam_n, rock_n, done_n, hold, qpar;
  logic signed [16:0] stall_n;
  logic signed [16:0] remi;

  function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    absdiff = d[32] ? 32'(33'd0 - d) : d[31:0];
  endfunction

  always_comb begin
    lraw_n  = in_q.raw_angle;
    turn_n  = turn1_q;
    pend_n  = pend1_q;
    start_n = started_q;
    ftgt_n  = feed_tgt_q;
    fired_n = fired_q;
    rem_n   = remain_q;
    jam_n   = jam_q;
    stall_n = stall1_q;
    rock_n  = rock_q;
    rec_n   = rec_q;
    done_n  = 1'b0;
    hold    = 1'b0;
    qpar    = dq_q[0];
    tot_r   = 32'({19'd0, lraw_n}) + turn_n * 32'(EncoderCounts);
    dist_r  = '0;
    dist_f  = '0;
    ftgt_c  = '0;
    tot_c   = '0;
    remi    = '0;
    if (in_q.attack_mode == fjrs_pkg::ModeDisabled ||
        in_q.attack_mode == fjrs_pkg::ModeCeaseFire) begin
      pend_n = '0; start_n = 1'b0; jam_n = 1'b0; stall_n = '0; rec_n = '0;
    end else begin
      if (recov_q) begin
        if (stalled_q) begin
          if (!qpar && rock_n) begin
            rock_n = 1'b0; rec_n = rec_n - {delta_q[29:0], 2'b00};
          end else if (qpar && !rock_n) begin
            rock_n = 1'b1; rec_n = rec_n + {delta_q[29:0], 2'b00};
          end
        end
        dist_r = absdiff(tot_r, rec_n);
        if (dist_r <= {13'd0, shot_angle_q}) begin
          jam_n = 1'b0; stall_n = '0; rec_n = '0;
        end else hold = 1'b1;
      end
      if (!hold) begin
        if (pend_n != 8'd0) begin
          tot_c = tot_r;
          if (!start_n) begin
            turn_n = ($signed({1'b0, in_q.raw_angle}) > $signed({1'b0, WrapS})) ? '1 : '0;
            tot_c  = 32'({19'd0, lraw_n}) + turn_n * 32'(EncoderCounts);
            ftgt_n = tot_c + dshot_q;
            start_n = 1'b1;
          end
          ftgt_c = ftgt_n;
          dist_f = absdiff(tot_c, ftgt_c);
          if (dist_f <= {16'd0, shot_angle_q[18:3]}) begin
            fired_n = fired_n + {8'd0, pend_n};
            remi    = $signed({1'b0, magazine_q}) - $signed({1'b0, fired_n});
            rem_n   = remi[16] ? 16'd0 : remi[15:0];
            pend_n  = '0; start_n = 1'b0; done_n = 1'b1;
            jam_n = 1'b0; stall_n = '0; rec_n = '0;
          end
          if (stalled_q) begin
            stall_n = (stall_n < 17'sd32767) ? stall_n + 17'sd1 : stall_n;
            if (stall_n > $signed({7'd0, stall_ticks_q})) begin
              rec_n = tot_c + {delta_q[30:0], 1'b0}; rock_n = 1'b1; jam_n = 1'b1;
            end
          end else begin
            stall_n = (stall_n > 17'sd0) ? stall_n - 17'sd10 : 17'sd0;
          end
        end else begin
          ftgt_n = tot_r;
        end
      end
    end
    tgt_n = hold ? rec_n : ftgt_n;
  end

  // Committed state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0; turn_q <= '0; pend_q <= '0; started_q <= 1'b0;
      feed_tgt_q <= '0; fired_q <= '0; remain_q <= '0; jam_q <= 1'b0;
      stall_q <= '0; rock_q <= 1'b0; rec_q <= '0;
    end else if (cmd_i.fin) begin
      last_raw_q <= lraw_n; turn_q <= turn_n; pend_q <= pend_n; started_q <= start_n;
      feed_tgt_q <= ftgt_n; fired_q <= fired_n; remain_q <= rem_n; jam_q <= jam_n;
      stall_q <= stall_n; rock_q <= rock_n; rec_q <= rec_n;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_data_o.aim_angle       <= tgt_n;
      out_data_o.total_angle     <= 32'({19'd0, lraw_n}) + turn_n * 32'(EncoderCounts);
      out_data_o.drive_enable    <= in_q.attack_mode != fjrs_pkg::ModeDisabled;
      out_data_o.jam_active      <= jam_n;
      out_data_o.shot_done       <= done_n;
      out_data_o.fired_count     <= fired_n;
      out_data_o.remaining_count <= rem_n;
    end
  end

  logic unused;
  assign unused = ^{EncW, ftgt_c, tot_c};

endmodule

// ----- src/feeder_jam_recovery_sequencer.sv -----
// ----------------------------------------------------------------------------
// feeder_jam_recovery_sequencer
// Tracks feeder rotor angle, sequences shot feeds and recovers from jams.
// ----------------------------------------------------------------------------
//  channel | signals                        | beat taken when
//  in      | in_valid_i/in_ready_o/in_data_i | valid and ready high
//  out     | out_valid_o/out_ready_i/out_data_o | valid and ready high
//  cfg     | cfg_we_i/cfg_idx_i/cfg_data_i  | write enable high
//
// A tick runs the load, prepare and commit states; while the jam rocking
// phase runs, the 15-step serial divider for the stall phase parity is added.
// Reset gives the register defaults and clears all tracking state.
// A result waits in the output register; the commit stalls only when that
// register is still full.
module feeder_jam_recovery_sequencer #(
  parameter int unsigned EncoderCounts = fjrs_pkg::EncoderCountsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fjrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fjrs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fjrs_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fjrs_pkg::out_item_t           out_data_o
);

  fjrs_pkg::cmd_t cmd;
  fjrs_pkg::sts_t sts;

  fjrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  fjrs_dp #(.EncoderCounts(EncoderCounts)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_data_o
  );

endmodule
